[hdl/cmfv_pkg.sv]
// Shared types, constants and helper functions of the chunked model file validator.
`default_nettype none
package cmfv_pkg;

    localparam int CfgIdxWidth = 3;

    localparam logic [2:0] REG_MAX_MATERIALS  = 3'd0;
    localparam logic [2:0] REG_MAX_MESHES     = 3'd1;
    localparam logic [2:0] REG_MAX_BUFFERS    = 3'd2;
    localparam logic [2:0] REG_MAX_ATTRIBUTES = 3'd3;
    localparam logic [2:0] REG_MAX_VERTICES   = 3'd4;
    localparam logic [2:0] REG_MAX_INDICES    = 3'd5;
    localparam logic [2:0] REG_MAX_STRIDE     = 3'd6;

    localparam logic [7:0] MAX_ATTR_TYPE = 8'd13;

    typedef struct packed {
        logic [15:0] max_materials;
        logic [15:0] max_meshes;
        logic [7:0]  max_buffers;
        logic [7:0]  max_attributes;
        logic [31:0] max_vertices;
        logic [31:0] max_indices;
        logic [8:0]  max_stride;
    } cfg_t;

    typedef enum logic [17:0] {
        PH_SIZE    = 18'h00001,
        PH_HEAD    = 18'h00002,
        PH_HSTR    = 18'h00004,
        PH_TAIL    = 18'h00008,
        PH_MATHDR  = 18'h00010,
        PH_MATSTR  = 18'h00020,
        PH_MATPAD  = 18'h00040,
        PH_MESHCNT = 18'h00080,
        PH_MESHA   = 18'h00100,
        PH_MESHB   = 18'h00200,
        PH_BUFHDR  = 18'h00400,
        PH_ATTR    = 18'h00800,
        PH_ATTRPAD = 18'h01000,
        PH_VSKIP   = 18'h02000,
        PH_IDXHDR  = 18'h04000,
        PH_ISKIP   = 18'h08000,
        PH_FOOT    = 18'h10000,
        PH_SINK    = 18'h20000
    } phase_t;

    function automatic logic [7:0] hier_tag(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0: r = 8'h2E;
            4'd1: r = 8'h43;
            4'd2: r = 8'h43;
            4'd3: r = 8'h34;
            4'd4: r = 8'h48;
            4'd5: r = 8'h53;
            4'd6: r = 8'h45;
            4'd7: r = 8'h52;
            4'd8: r = 8'h48;
            4'd9: r = 8'h53;
            4'd10: r = 8'h45;
            4'd11: r = 8'h52;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] scene_tag(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd8: r = 8'h32;
            4'd9: r = 8'h43;
            4'd10: r = 8'h53;
            4'd11: r = 8'h47;
            default: r = hier_tag(idx);
        endcase
        return r;
    endfunction

    function automatic logic [7:0] buf_magic(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0: r = 8'h44;
            2'd1: r = 8'h58;
            2'd2: r = 8'h54;
            default: r = 8'h56;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] stride_for(input logic [7:0] f);
        logic [4:0] r;
        case (f)
            8'd2: r = 5'd8;
            8'd3: r = 5'd12;
            8'd4: r = 5'd16;
            8'd5: r = 5'd4;
            8'd6: r = 5'd8;
            8'd7, 8'd8, 8'd9: r = 5'd4;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[hdl/cmfv_cfg_regs.sv]
// Limit registers written through the configuration channel.
`default_nettype none
module cmfv_cfg_regs (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire logic [2:0]             wr_index,
    input  wire logic [31:0]            wr_data,
    output cmfv_pkg::cfg_t              cfg
);

    cmfv_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_materials  <= 16'd4096;
            cfg_reg.max_meshes     <= 16'd4096;
            cfg_reg.max_buffers    <= 8'd16;
            cfg_reg.max_attributes <= 8'd32;
            cfg_reg.max_vertices   <= 32'd16777216;
            cfg_reg.max_indices    <= 32'd67108864;
            cfg_reg.max_stride     <= 9'd256;
        end
        else if (wr_en)
        begin
            case (wr_index)
                cmfv_pkg::REG_MAX_MATERIALS:  cfg_reg.max_materials  <= wr_data[15:0];
                cmfv_pkg::REG_MAX_MESHES:     cfg_reg.max_meshes     <= wr_data[15:0];
                cmfv_pkg::REG_MAX_BUFFERS:    cfg_reg.max_buffers    <= wr_data[7:0];
                cmfv_pkg::REG_MAX_ATTRIBUTES: cfg_reg.max_attributes <= wr_data[7:0];
                cmfv_pkg::REG_MAX_VERTICES:   cfg_reg.max_vertices   <= wr_data;
                cmfv_pkg::REG_MAX_INDICES:    cfg_reg.max_indices    <= wr_data;
                cmfv_pkg::REG_MAX_STRIDE:     cfg_reg.max_stride     <= wr_data[8:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

[hdl/cmfv_parser.sv]
// Parse state machine that checks one file byte per step.
`default_nettype none
module cmfv_parser (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire logic [7:0]     data_byte,
    input  wire logic           last_byte,
    input  cmfv_pkg::cfg_t      cfg,
    output logic                result
);

    cmfv_pkg::phase_t phase_reg, phase_next;
    logic [31:0] acc_reg, acc_next;
    logic [3:0]  fcnt_reg, fcnt_next;
    logic [31:0] chunk_reg, chunk_next;
    logic [40:0] skip_reg, skip_next;
    logic [31:0] mat_reg, mat_next;
    logic [31:0] mesh_reg, mesh_next;
    logic [7:0]  buf_left_reg, buf_left_next;
    logic [7:0]  buf_total_reg, buf_total_next;
    logic [7:0]  attr_reg, attr_next;
    logic [31:0] vcount_reg, vcount_next;
    logic [9:0]  stride_reg, stride_next;
    logic [9:0]  span_reg, span_next;
    logic [2:0]  str_reg, str_next;
    logic        scene_reg, scene_next;
    logic        failed_reg, failed_next;
    logic [41:0] prod_full;
    logic [41:0] prod_reg;

    // The vertex skip length is taken during the six pad bytes after the
    // attribute list, so the product has time to settle in a register.
    assign prod_full = stride_reg * vcount_reg;

    always_comb
    begin
        logic [31:0] acc_sh;
        logic [3:0]  inc;
        logic        fail_hit;
        logic [4:0]  s;
        logic [9:0]  ss;
        logic [9:0]  sp;
        logic [7:0]  attr_dec;
        logic [40:0] skip_dec;

        acc_sh   = {acc_reg[23:0], data_byte};
        inc      = fcnt_reg + 4'd1;
        fail_hit = 1'b0;
        s        = cmfv_pkg::stride_for(data_byte);
        ss       = stride_reg + {5'd0, s};
        sp       = {2'd0, data_byte} + {5'd0, acc_reg[4:0]};
        attr_dec = attr_reg - 8'd1;
        skip_dec = skip_reg - 41'd1;

        phase_next     = phase_reg;
        acc_next       = acc_reg;
        fcnt_next      = fcnt_reg;
        chunk_next     = chunk_reg;
        skip_next      = skip_reg;
        mat_next       = mat_reg;
        mesh_next      = mesh_reg;
        buf_left_next  = buf_left_reg;
        buf_total_next = buf_total_reg;
        attr_next      = attr_reg;
        vcount_next    = vcount_reg;
        stride_next    = stride_reg;
        span_next      = span_reg;
        str_next       = str_reg;
        scene_next     = scene_reg;
        failed_next    = failed_reg;

        case (phase_reg)
            cmfv_pkg::PH_SINK:
            begin
            end
            cmfv_pkg::PH_SIZE:
            begin
                acc_next  = acc_sh;
                fcnt_next = inc;
                if (inc == 4'd4)
                begin
                    if (acc_sh < 32'd16)
                    begin
                        fail_hit = 1'b1;
                    end
                    else
                    begin
                        chunk_next = acc_sh;
                        phase_next = cmfv_pkg::PH_HEAD;
                        fcnt_next  = 4'd0;
                        acc_next   = 32'd3;
                    end
                end
            end
            cmfv_pkg::PH_HEAD:
            begin
                // Bits 0 and 1 of the accumulator track the two known types.
                if (fcnt_reg < 4'd12)
                begin
                    if (data_byte != cmfv_pkg::hier_tag(fcnt_reg))
                    begin
                        acc_next[0] = 1'b0;
                    end
                    if (data_byte != cmfv_pkg::scene_tag(fcnt_reg))
                    begin
                        acc_next[1] = 1'b0;
                    end
                end
                fcnt_next = inc;
                if (inc == 4'd0)
                begin
                    fcnt_next = 4'd0;
                    acc_next  = 32'd0;
                    if (acc_reg[0])
                    begin
                        str_next   = 3'd3;
                        phase_next = cmfv_pkg::PH_HSTR;
                    end
                    else if (acc_reg[1])
                    begin
                        scene_next = 1'b1;
                        phase_next = cmfv_pkg::PH_MATHDR;
                    end
                    else
                    begin
                        phase_next = cmfv_pkg::PH_TAIL;
                    end
                end
            end
            cmfv_pkg::PH_HSTR:
            begin
                if (data_byte == 8'd0)
                begin
                    str_next = str_reg - 3'd1;
                    if (str_next == 3'd0)
                    begin
                        phase_next = cmfv_pkg::PH_TAIL;
                    end
                end
            end
            cmfv_pkg::PH_TAIL:
            begin
            end
            cmfv_pkg::PH_MATHDR:
            begin
                acc_next  = acc_sh;
                fcnt_next = inc;
                if (inc == 4'd4)
                begin
                    mat_next = acc_sh;
                end
                if (inc == 4'd8)
                begin
                    fcnt_next = 4'd0;
                    acc_next  = 32'd0;
                    if (mat_reg > {16'd0, cfg.max_materials})
                    begin
                        fail_hit = 1'b1;
                    end
                    else if (mat_reg != 32'd0)
                    begin
                        str_next   = 3'd4;
                        phase_next = cmfv_pkg::PH_MATSTR;
                    end
                    else
                    begin
                        phase_next = cmfv_pkg::PH_MESHCNT;
                    end
                end
            end
            cmfv_pkg::PH_MATSTR:
            begin
                if (data_byte == 8'd0)
                begin
                    str_next = str_reg - 3'd1;
                    if (str_next == 3'd0)
                    begin
                        phase_next = cmfv_pkg::PH_MATPAD;
                        fcnt_next  = 4'd0;
                        acc_next   = 32'd0;
                    end
                end
            end
            cmfv_pkg::PH_MATPAD:
            begin
                fcnt_next = inc;
                if (inc == 4'd3)
                begin
                    mat_next  = mat_reg - 32'd1;
                    fcnt_next = 4'd0;
                    acc_next  = 32'd0;
                    if (mat_next != 32'd0)
                    begin
                        str_next   = 3'd4;
                        phase_next = cmfv_pkg::PH_MATSTR;
                    end
                    else
                    begin
                        phase_next = cmfv_pkg::PH_MESHCNT;
                    end
                end
            end
            cmfv_pkg::PH_MESHCNT:
            begin
                acc_next  = acc_sh;
                fcnt_next = inc;
                if (inc == 4'd8)
                begin
                    mesh_next = acc_sh;
                end
                if (inc == 4'd12)
                begin
                    if (mesh_reg == 32'd0 || mesh_reg > {16'd0, cfg.max_meshes})
                    begin
                        fail_hit = 1'b1;
                    end
                    else
                    begin
                        phase_next = cmfv_pkg::PH_MESHA;
                        fcnt_next  = 4'd0;
                        acc_next   = 32'd0;
                    end
                end
            end
            cmfv_pkg::PH_MESHA:
            begin
                acc_next  = acc_sh;
                fcnt_next = inc;
                if (inc == 4'd12)
                begin
                    if (acc_sh == 32'd0 || acc_sh > {24'd0, cfg.max_buffers})
                    begin
                        fail_hit = 1'b1;
                    end
                    else
                    begin
                        buf_total_next = acc_sh[7:0];
                        buf_left_next  = acc_sh[7:0];
                        phase_next     = cmfv_pkg::PH_MESHB;
                        fcnt_next      = 4'd0;
                        acc_next       = 32'd0;
                    end
                end
            end
            cmfv_pkg::PH_MESHB:
            begin
                acc_next  = acc_sh;
                fcnt_next = inc;
                if (inc == 4'd12)
                begin
                    if (acc_sh == 32'd0 || acc_sh > cfg.max_vertices)
                    begin
                        fail_hit = 1'b1;
                    end
                    else
                    begin
                        vcount_next = acc_sh;
                        phase_next  = cmfv_pkg::PH_BUFHDR;
                        fcnt_next   = 4'd0;
                        acc_next    = 32'd0;
                    end
                end
            end
            cmfv_pkg::PH_BUFHDR:
            begin
                if (fcnt_reg < 4'd4 && data_byte != cmfv_pkg::buf_magic(fcnt_reg[1:0]))
                begin
                    fail_hit = 1'b1;
                end
                else
                begin
                    acc_next  = acc_sh;
                    fcnt_next = inc;
                    if (inc == 4'd12)
                    begin
                        if (acc_sh == 32'd0 || acc_sh > {24'd0, cfg.max_attributes})
                        begin
                            fail_hit = 1'b1;
                        end
                        else
                        begin
                            attr_next   = acc_sh[7:0];
                            stride_next = 10'd0;
                            span_next   = 10'd0;
                            phase_next  = cmfv_pkg::PH_ATTR;
                            fcnt_next   = 4'd0;
                            acc_next    = 32'd0;
                        end
                    end
                end
            end
            cmfv_pkg::PH_ATTR:
            begin
                // Each attribute is a type, format, offset triple.
                if (fcnt_reg == 4'd0)
                begin
                    if (data_byte > cmfv_pkg::MAX_ATTR_TYPE)
                    begin
                        fail_hit = 1'b1;
                    end
                end
                else if (fcnt_reg == 4'd1)
                begin
                    if (s == 5'd0 || ss > {1'b0, cfg.max_stride})
                    begin
                        fail_hit = 1'b1;
                    end
                    else
                    begin
                        stride_next = ss;
                        acc_next    = {27'd0, s};
                    end
                end
                else if (sp > span_reg)
                begin
                    span_next = sp;
                end
                if (!fail_hit)
                begin
                    fcnt_next = inc;
                    if (inc == 4'd3)
                    begin
                        fcnt_next = 4'd0;
                        attr_next = attr_dec;
                        if (attr_dec == 8'd0)
                        begin
                            if (stride_next == 10'd0 || span_next > stride_next)
                            begin
                                fail_hit = 1'b1;
                            end
                            else
                            begin
                                phase_next = cmfv_pkg::PH_ATTRPAD;
                                acc_next   = 32'd0;
                            end
                        end
                    end
                end
            end
            cmfv_pkg::PH_ATTRPAD:
            begin
                fcnt_next = inc;
                if (inc == 4'd6)
                begin
                    skip_next  = prod_reg[40:0] + 41'd16;
                    phase_next = cmfv_pkg::PH_VSKIP;
                    fcnt_next  = 4'd0;
                    acc_next   = 32'd0;
                end
            end
            cmfv_pkg::PH_VSKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 41'd0)
                begin
                    buf_left_next = buf_left_reg - 8'd1;
                    fcnt_next     = 4'd0;
                    acc_next      = 32'd0;
                    phase_next    = (buf_left_next != 8'd0) ? cmfv_pkg::PH_BUFHDR
                                                            : cmfv_pkg::PH_IDXHDR;
                end
            end
            cmfv_pkg::PH_IDXHDR:
            begin
                acc_next  = acc_sh;
                fcnt_next = inc;
                if (inc == 4'd4)
                begin
                    skip_next = {9'd0, acc_sh};
                end
                if (inc == 4'd8)
                begin
                    if ((acc_sh != 32'd2 && acc_sh != 32'd4) || skip_reg < 41'd3
                        || skip_reg > {9'd0, cfg.max_indices})
                    begin
                        fail_hit = 1'b1;
                    end
                    else
                    begin
                        skip_next  = (acc_sh == 32'd4) ? {skip_reg[38:0], 2'b00}
                                                       : {skip_reg[39:0], 1'b0};
                        phase_next = cmfv_pkg::PH_ISKIP;
                        fcnt_next  = 4'd0;
                        acc_next   = 32'd0;
                    end
                end
            end
            cmfv_pkg::PH_ISKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 41'd0)
                begin
                    skip_next  = 41'd70 + {31'd0, buf_total_reg, 2'b00};
                    phase_next = cmfv_pkg::PH_FOOT;
                    fcnt_next  = 4'd0;
                    acc_next   = 32'd0;
                end
            end
            cmfv_pkg::PH_FOOT:
            begin
                skip_next = skip_dec;
                if (skip_dec == 41'd0)
                begin
                    mesh_next  = mesh_reg - 32'd1;
                    fcnt_next  = 4'd0;
                    acc_next   = 32'd0;
                    phase_next = (mesh_next != 32'd0) ? cmfv_pkg::PH_MESHA
                                                      : cmfv_pkg::PH_TAIL;
                end
            end
            default:
            begin
                fail_hit = 1'b1;
            end
        endcase

        // Every byte inside a chunk counts down its length.
        if (!fail_hit && phase_reg != cmfv_pkg::PH_SIZE && phase_reg != cmfv_pkg::PH_SINK)
        begin
            chunk_next = chunk_reg - 32'd1;
            if (chunk_next == 32'd0)
            begin
                if (phase_next != cmfv_pkg::PH_TAIL)
                begin
                    fail_hit = 1'b1;
                end
                else
                begin
                    phase_next = cmfv_pkg::PH_SIZE;
                    fcnt_next  = 4'd0;
                    acc_next   = 32'd0;
                end
            end
        end

        if (fail_hit)
        begin
            failed_next = 1'b1;
            phase_next  = cmfv_pkg::PH_SINK;
        end

        result = phase_next == cmfv_pkg::PH_SIZE && fcnt_next == 4'd0 && scene_next
                 && !failed_next;

        // The final byte of a file leaves the parser ready for the next file.
        if (last_byte)
        begin
            phase_next     = cmfv_pkg::PH_SIZE;
            acc_next       = 32'd0;
            fcnt_next      = 4'd0;
            chunk_next     = 32'd0;
            skip_next      = 41'd0;
            mat_next       = 32'd0;
            mesh_next      = 32'd0;
            buf_left_next  = 8'd0;
            buf_total_next = 8'd0;
            attr_next      = 8'd0;
            vcount_next    = 32'd0;
            stride_next    = 10'd0;
            span_next      = 10'd0;
            str_next       = 3'd0;
            scene_next     = 1'b0;
            failed_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= cmfv_pkg::PH_SIZE;
            acc_reg       <= 32'd0;
            fcnt_reg      <= 4'd0;
            chunk_reg     <= 32'd0;
            skip_reg      <= 41'd0;
            mat_reg       <= 32'd0;
            mesh_reg      <= 32'd0;
            buf_left_reg  <= 8'd0;
            buf_total_reg <= 8'd0;
            attr_reg      <= 8'd0;
            vcount_reg    <= 32'd0;
            stride_reg    <= 10'd0;
            span_reg      <= 10'd0;
            str_reg       <= 3'd0;
            scene_reg     <= 1'b0;
            failed_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            fcnt_reg      <= fcnt_next;
            chunk_reg     <= chunk_next;
            skip_reg      <= skip_next;
            mat_reg       <= mat_next;
            mesh_reg      <= mesh_next;
            buf_left_reg  <= buf_left_next;
            buf_total_reg <= buf_total_next;
            attr_reg      <= attr_next;
            vcount_reg    <= vcount_next;
            stride_reg    <= stride_next;
            span_reg      <= span_next;
            str_reg       <= str_next;
            scene_reg     <= scene_next;
            failed_reg    <= failed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full;
    end

endmodule
`default_nettype wire

[hdl/chunked_model_file_validator.sv]
// Top level of the chunked model file validator.
// The block takes one file byte per cycle and answers once per file, on the
// item that carries last_byte, with model_valid set when every structural
// check passed. A byte is held in an input register until the parse state
// machine checks it; a result item waits in an output register. Input keeps
// moving at one byte a cycle unless a result waits and the byte in hand is the
// last byte of the next file. Users must write limits through the configuration
// channel only while no file is in flight; the block does not enforce it.
`default_nettype none
module chunked_model_file_validator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             model_valid,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cmfv_pkg::cfg_t cfg;
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       s1_adv;
    logic       step;
    logic       result;
    logic       out_valid_reg;
    logic       model_valid_reg;

    assign cfg_ready = 1'b1;

    cmfv_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Only a last byte produces a result item, so only it waits on the output.
    assign s1_adv   = !s1_last_reg || !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign step     = s1_valid_reg && s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

    cmfv_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (s1_byte_reg),
        .last_byte (s1_last_reg),
        .cfg       (cfg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && s1_last_reg)
        begin
            model_valid_reg <= result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign model_valid = model_valid_reg;

endmodule
`default_nettype wire

[hdl/cmfv_checker.sv]
// Port-level assertions for the validator, bound to its top level.
`default_nettype none
module cmfv_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic model_valid
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(model_valid))
        else $error("result item changed while stalled");

    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a waiting result item");

    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("result item dropped without being taken");

endmodule

bind chunked_model_file_validator cmfv_checker u_cmfv_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .model_valid (model_valid)
);
`default_nettype wire
